FILE: rtl/amdn_pkg.sv
// ----------------------------------------------------------------------------
// amdn_pkg
// Shared widths, codes and word types of the multigraph adjacency matrix unit.
// ----------------------------------------------------------------------------
package amdn_pkg;

  // default sizes of the matrix and of the command queue
  localparam int MAX_VERT_DEF    = 32;
  localparam int COUNT_BITS_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  // fixed field widths
  localparam int VERT_W     = 6;
  localparam int REQ_W      = 2;
  localparam int VALUE_W    = 13;
  localparam int STATUS_W   = 2;
  localparam int RESULT_CAP = 32;

  localparam logic [VERT_W-1:0]  VC_RESET  = 6'd32;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 13'h1fff;

  // request codes on the input channel
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DEGREE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NEIGH  = 2'd3;

  // status codes on the result channel
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // classified command handed from the front to the back
  typedef enum logic [2:0] {
    CMD_CLEAR,
    CMD_ADD,
    CMD_DEGREE,
    CMD_NEIGH,
    CMD_RANGE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [VERT_W-1:0]   vert_a;
    logic [VERT_W-1:0]   vert_b;
  } cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

endpackage

FILE: rtl/amdn_if.sv
// ----------------------------------------------------------------------------
// amdn_if
// Valid/ready channels of the adjacency matrix unit: request and result words.
// ----------------------------------------------------------------------------
interface amdn_in_if;
  import amdn_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [VERT_W-1:0] vertex_a;
  logic [VERT_W-1:0] vertex_b;

  modport source (output valid, output req_type, output vertex_a, output vertex_b,
                  input ready);
  modport sink   (input valid, input req_type, input vertex_a, input vertex_b,
                  output ready);
endinterface

interface amdn_out_if;
  import amdn_pkg::*;

  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, output value, output status, output last, input ready);
  modport sink   (input valid, input value, input status, input last, output ready);
endinterface

FILE: rtl/amdn_front.sv
// ----------------------------------------------------------------------------
// amdn_front
// Takes request words, checks the vertices against the active count and
// pushes one classified command into the queue.
// ----------------------------------------------------------------------------
module amdn_front (
  amdn_in_if.sink                  in_chan,
  input  logic [amdn_pkg::VERT_W-1:0] nv,
  input  logic                     init_done,
  input  logic                     q_full,
  output logic                     q_push,
  output amdn_pkg::cmd_t           q_word
);
  import amdn_pkg::*;

  logic a_ok;
  logic b_ok;

  assign a_ok = (in_chan.vertex_a != '0) && (in_chan.vertex_a <= nv);
  assign b_ok = (in_chan.vertex_b != '0) && (in_chan.vertex_b <= nv);

  // no word is taken while the matrix is being swept after reset
  assign in_chan.ready = !q_full && init_done;
  assign q_push        = in_chan.valid && in_chan.ready;

  always_comb begin
    q_word.vert_a = in_chan.vertex_a;
    q_word.vert_b = in_chan.vertex_b;
    case (in_chan.req_type)
      REQ_CLEAR:  q_word.op = CMD_CLEAR;
      REQ_ADD:    q_word.op = (a_ok && b_ok) ? CMD_ADD : CMD_RANGE;
      REQ_DEGREE: q_word.op = a_ok ? CMD_DEGREE : CMD_RANGE;
      REQ_NEIGH:  q_word.op = a_ok ? CMD_NEIGH : CMD_RANGE;
      default:    q_word.op = CMD_RANGE;
    endcase
  end

endmodule

FILE: rtl/amdn_queue.sv
// ----------------------------------------------------------------------------
// amdn_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module amdn_queue #(
  parameter int DEPTH = amdn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  amdn_pkg::cmd_t push_word,
  output logic           full,
  input  logic           pop,
  output amdn_pkg::cmd_t pop_word,
  output logic           empty
);
  import amdn_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t           slots [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push;
  logic           do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_word = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_word;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/amdn_back.sv
// ----------------------------------------------------------------------------
// amdn_back
// Executes queued commands on the edge count memory: clearing sweep, edge
// add by read-modify-write, and a row walk for degree and neighbor lists.
// ----------------------------------------------------------------------------
module amdn_back #(
  parameter int MAX_VERT   = amdn_pkg::MAX_VERT_DEF,
  parameter int COUNT_BITS = amdn_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [amdn_pkg::VERT_W-1:0] nv,
  input  logic                        q_vld,
  input  amdn_pkg::cmd_t              q_word,
  output logic                        q_pop,
  output logic                        init_done,
  amdn_out_if.source                  out_chan
);
  import amdn_pkg::*;

  localparam int RW      = $clog2(MAX_VERT);
  localparam int AW      = 2 * RW;
  localparam int DEPTH   = 1 << AW;
  localparam int CNT_W   = RW + 1;
  localparam int FOUND_W = $clog2(RESULT_CAP + 1);
  localparam int ACC_W   = ((COUNT_BITS > VALUE_W) ? COUNT_BITS : VALUE_W) + 1;
  localparam logic [FOUND_W-1:0]    CAP     = FOUND_W'(RESULT_CAP);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_RD1,
    S_WR1,
    S_RD2,
    S_WR2,
    S_WALK,
    S_ERR
  } state_t;

  // edge count memory
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [AW-1:0]         sweep_r, sweep_nxt;
  logic [CNT_W-1:0]      col_r, col_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [RW-1:0]         rd_col_r, rd_col_nxt;
  logic [VALUE_W-1:0]    acc_r, acc_nxt;
  logic                  pend_vld_r, pend_vld_nxt;
  logic [RW-1:0]         pend_col_r, pend_col_nxt;
  logic [FOUND_W-1:0]    found_r, found_nxt;
  logic                  out_vld_r, out_vld_nxt;
  result_t               out_word_r, out_word_nxt;

  logic                  push;
  result_t               push_word;
  logic                  push_ok;
  logic [RW-1:0]         row_a;
  logic [RW-1:0]         row_b;
  logic [CNT_W-1:0]      nv_c;
  logic [ACC_W-1:0]      sum_w;
  logic                  hit;
  logic                  stall;
  logic                  at_end;

  assign row_a   = RW'(cmd_r.vert_a - VERT_W'(1));
  assign row_b   = RW'(cmd_r.vert_b - VERT_W'(1));
  assign nv_c    = CNT_W'(nv);
  assign push_ok = !out_vld_r || out_chan.ready;
  assign sum_w   = ACC_W'(acc_r) + ACC_W'(rd_data_r);

  // a count of exactly one is a neighbor, up to the result cap
  assign hit    = rd_vld_r && (cmd_r.op == CMD_NEIGH) && (found_r < CAP) &&
                  (rd_data_r == COUNT_BITS'(1));
  assign stall  = hit && pend_vld_r && !push_ok;
  assign at_end = !rd_vld_r && ((col_r == nv_c) || (found_r == CAP));

  assign init_done = (state_r != S_INIT);

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    sweep_nxt    = sweep_r;
    col_nxt      = col_r;
    rd_vld_nxt   = rd_vld_r;
    rd_col_nxt   = rd_col_r;
    acc_nxt      = acc_r;
    pend_vld_nxt = pend_vld_r;
    pend_col_nxt = pend_col_r;
    found_nxt    = found_r;
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = sweep_r;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = {row_a, row_b};
    push         = 1'b0;
    push_word    = '0;

    case (state_r)
      S_INIT, S_CLEAR: begin
        mem_we    = 1'b1;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_vld) begin
          q_pop        = 1'b1;
          cmd_nxt      = q_word;
          col_nxt      = '0;
          rd_vld_nxt   = 1'b0;
          acc_nxt      = '0;
          pend_vld_nxt = 1'b0;
          found_nxt    = '0;
          case (q_word.op)
            CMD_CLEAR:  state_nxt = S_CLEAR;
            CMD_ADD:    state_nxt = S_RD1;
            CMD_DEGREE: state_nxt = S_WALK;
            CMD_NEIGH:  state_nxt = S_WALK;
            default:    state_nxt = S_ERR;
          endcase
        end
      end
      S_RD1: begin
        mem_re    = 1'b1;
        state_nxt = S_WR1;
      end
      S_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = {row_a, row_b};
        mem_wdata = (rd_data_r == CNT_MAX) ? rd_data_r : rd_data_r + COUNT_BITS'(1);
        state_nxt = S_RD2;
      end
      S_RD2: begin
        // the mirrored entry is read after the first write, so a self-loop counts twice
        mem_re    = 1'b1;
        mem_raddr = {row_b, row_a};
        state_nxt = S_WR2;
      end
      S_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = {row_b, row_a};
        mem_wdata = (rd_data_r == CNT_MAX) ? rd_data_r : rd_data_r + COUNT_BITS'(1);
        state_nxt = S_IDLE;
      end
      S_WALK: begin
        if (at_end) begin
          if (push_ok) begin
            push           = 1'b1;
            push_word.last = 1'b1;
            if (cmd_r.op == CMD_DEGREE) begin
              push_word.value  = acc_r;
              push_word.status = ST_OK;
            end else if (pend_vld_r) begin
              push_word.value  = VALUE_W'(pend_col_r) + VALUE_W'(1);
              push_word.status = ST_OK;
            end else begin
              push_word.value  = '0;
              push_word.status = ST_EMPTY;
            end
            state_nxt = S_IDLE;
          end
        end else if (!stall) begin
          if (rd_vld_r && (cmd_r.op == CMD_DEGREE)) begin
            acc_nxt = (sum_w > ACC_W'(VALUE_MAX)) ? VALUE_MAX : VALUE_W'(sum_w);
          end
          // the held neighbor goes out once a later one shows it is not last
          if (hit) begin
            if (pend_vld_r) begin
              push             = 1'b1;
              push_word.value  = VALUE_W'(pend_col_r) + VALUE_W'(1);
              push_word.status = ST_OK;
              push_word.last   = 1'b0;
            end
            pend_vld_nxt = 1'b1;
            pend_col_nxt = rd_col_r;
            found_nxt    = found_r + FOUND_W'(1);
          end
          if ((col_r != nv_c) && (found_r < CAP)) begin
            mem_re     = 1'b1;
            mem_raddr  = {row_a, col_r[RW-1:0]};
            rd_vld_nxt = 1'b1;
            rd_col_nxt = col_r[RW-1:0];
            col_nxt    = col_r + CNT_W'(1);
          end else begin
            rd_vld_nxt = 1'b0;
          end
        end
      end
      S_ERR: begin
        if (push_ok) begin
          push             = 1'b1;
          push_word.value  = '0;
          push_word.status = ST_RANGE;
          push_word.last   = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_vld_nxt  = push || (out_vld_r && !out_chan.ready);
    out_word_nxt = push ? push_word : out_word_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    col_r      <= col_nxt;
    rd_col_r   <= rd_col_nxt;
    acc_r      <= acc_nxt;
    pend_col_r <= pend_col_nxt;
    out_word_r <= out_word_nxt;
    if (!rst_n) begin
      state_r    <= S_INIT;
      sweep_r    <= '0;
      rd_vld_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      found_r    <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      sweep_r    <= sweep_nxt;
      rd_vld_r   <= rd_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      found_r    <= found_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  assign out_chan.valid  = out_vld_r;
  assign out_chan.value  = out_word_r.value;
  assign out_chan.status = out_word_r.status;
  assign out_chan.last   = out_word_r.last;

  a_rd_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> state_r == S_WALK)
    else $error("read data pending outside a row walk");

  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("memory written and read in the same cycle");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    found_r <= CAP)
    else $error("neighbor count past the result cap");

  a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_word_r.status != ST_OK)) |-> (out_word_r.value == '0) &&
    out_word_r.last)
    else $error("status word with nonzero value or without last");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r != S_IDLE)
    else $error("command popped but not started");

endmodule

FILE: rtl/adjacency_matrix_degree_neighbors_unit.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_degree_neighbors_unit
// Undirected multigraph kept as a square matrix of saturating edge counts,
// with clear, add edge, degree and neighbor listing requests.
// ----------------------------------------------------------------------------
//  channel  direction  word                              handshake
//  in_chan  in         req_type, vertex_a, vertex_b      valid/ready
//  out_chan out        value, status, last               valid/ready
//  cfg_*    in         vertex_count (6 bits)             write enable only
//
// degree and neighbor requests walk one row, one entry a cycle unless the
// output stalls; add edge reads and writes the entry, then its mirror; an out
// of range request gets a range status word; clear sweeps all 2^(2*clog2(MAX_VERT))
// memory entries (1024 by default), as does reset, with in_chan.ready low until
// that sweep ends. A queue (two words by default) keeps input flowing while the
// output register waits; a stalled result holds the row walk in place.
// ----------------------------------------------------------------------------
module adjacency_matrix_degree_neighbors_unit #(
  parameter int MAX_VERT    = amdn_pkg::MAX_VERT_DEF,
  parameter int COUNT_BITS  = amdn_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = amdn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [amdn_pkg::VERT_W-1:0] cfg_wdata,
  amdn_in_if.sink                     in_chan,
  amdn_out_if.source                  out_chan
);
  import amdn_pkg::*;

  logic [VERT_W-1:0] vc_r, vc_nxt;
  logic [VERT_W-1:0] nv;
  logic              init_done;
  logic              q_full;
  logic              q_push;
  cmd_t              q_in_word;
  logic              q_pop;
  cmd_t              q_out_word;
  logic              q_empty;

  assign vc_nxt = cfg_we ? cfg_wdata : vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= VC_RESET;
    end else begin
      vc_r <= vc_nxt;
    end
  end

  // active vertex count is capped by the matrix size
  assign nv = ((VERT_W + 1)'(vc_r) > (VERT_W + 1)'(MAX_VERT)) ? VERT_W'(MAX_VERT) : vc_r;

  amdn_front u_front (
    .in_chan   (in_chan),
    .nv        (nv),
    .init_done (init_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_word    (q_in_word)
  );

  amdn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_in_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (q_out_word),
    .empty     (q_empty)
  );

  amdn_back #(
    .MAX_VERT   (MAX_VERT),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .nv        (nv),
    .q_vld     (!q_empty),
    .q_word    (q_out_word),
    .q_pop     (q_pop),
    .init_done (init_done),
    .out_chan  (out_chan)
  );

endmodule
